/* hdl/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int LIVE_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 48'd268435456;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 48'd285212672;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_ZERO_SIZE    = 2'd1,
        STATUS_NO_MEMORY    = 2'd2,
        STATUS_UNKNOWN_FREE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND,
        S_SIZE,
        S_FIT,
        S_BUMP,
        S_FIND,
        S_MERGE,
        S_FLUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] len;
        logic              busy;
    } record_t;

endpackage

/* hdl/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator with free-block coalescing: top level.
//
// The block takes one allocate or free request at a time over a valid/ready
// channel and returns one result per request over a second valid/ready
// channel. Block records (start, length, busy) live in a RAM of MAX_BLOCKS
// entries kept in ascending address order; a small sequencer walks that RAM
// through its single read port, one record per cycle. An allocation scans the
// table for the first free record that fits, else bumps the heap pointer;
// a bit-serial remainder comes first when ALIGN_BYTES is not a power of two.
// A free runs a search pass up to the matching record, then one streaming
// compaction pass from the record before it to the end of the table, where
// touching free neighbors are merged and later records slide down. Zero-size
// allocations and frees of address zero go straight to S_DONE. Running totals
// of busy bytes, free bytes and live blocks are kept in registers and come
// with every result. The result sits in an output register, so a new request
// is taken while the previous result still waits for out_ready. Register 0
// (heap_base) reloads the bump pointer only while the table is empty;
// register 1 is heap_limit. The record RAM needs no clearing after reset.
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS  = 64,
    parameter int ALIGN_BYTES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // request channel
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         operation,
    input  logic [31:0]  request_size,
    input  logic [47:0]  free_address,
    // result channel
    output logic         out_valid,
    input  logic         out_ready,
    output logic [47:0]  address,
    output logic [1:0]   status,
    output logic [47:0]  allocated_bytes,
    output logic [47:0]  free_bytes,
    output logic [6:0]   live_blocks,
    // configuration write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data
);

    localparam int ADDR_W     = ffha_pkg::ADDR_W;
    localparam int SIZE_W     = ffha_pkg::SIZE_W;
    localparam int LIVE_W     = ffha_pkg::LIVE_W;
    localparam int AEXT_W     = ADDR_W + 1;
    localparam int RND_W      = SIZE_W + 1;
    localparam int BIT_W      = $clog2(SIZE_W);
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int REC_W      = $bits(ffha_pkg::record_t);
    localparam int REM_W      = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    localparam bit ALIGN_POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);

    localparam logic [RND_W-1:0]  ALIGN_M1  = RND_W'(ALIGN_BYTES - 1);
    localparam logic [RND_W-1:0]  ALIGN_C   = RND_W'(ALIGN_BYTES);
    localparam logic [REM_W:0]    ALIGN_R   = (REM_W + 1)'(ALIGN_BYTES);
    localparam logic [CNT_W-1:0]  TABLE_MAX = CNT_W'(MAX_BLOCKS);

    // sequencer and control state
    ffha_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   bump_reg, bump_next;
    logic [ADDR_W-1:0]   limit_reg, limit_next;
    logic [ADDR_W-1:0]   used_reg, used_next;
    logic [ADDR_W-1:0]   unused_reg, unused_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic                dv_reg, dv_next;
    logic                acc_v_reg, acc_v_next;
    logic                out_valid_reg, out_valid_next;

    // working registers
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]   faddr_reg, faddr_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [RND_W-1:0]    rounded_reg, rounded_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    tag_reg, tag_next;
    logic [IDX_W-1:0]    wr_reg, wr_next;
    ffha_pkg::record_t   acc_reg, acc_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    ffha_pkg::status_t   res_status_reg, res_status_next;

    // result register
    logic [ADDR_W-1:0]   address_reg, address_next;
    ffha_pkg::status_t   status_reg, status_next;
    logic [ADDR_W-1:0]   alloc_out_reg, alloc_out_next;
    logic [ADDR_W-1:0]   free_out_reg, free_out_next;
    logic [LIVE_W-1:0]   live_out_reg, live_out_next;

    // record RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    ffha_pkg::record_t   ram_wrec;
    logic [REC_W-1:0]    ram_rdata;
    ffha_pkg::record_t   rd_rec;

    // shared datapath
    logic [RND_W-1:0]    size_ext;
    logic [RND_W-1:0]    rounded_c;
    logic [REM_W:0]      rem_shift;
    logic [REM_W:0]      rem_diff;
    logic [AEXT_W-1:0]   bump_sum;
    logic                bump_over;
    logic                table_full;
    logic                scan_more;
    logic                fit_hit;
    logic                find_hit;
    logic [AEXT_W-1:0]   acc_end;
    logic [RND_W-1:0]    merge_sum;
    logic                can_merge;
    logic [IDX_W-1:0]    merge_first;

    ffha_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_BLOCKS)
    ) u_records (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrec),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec    = ffha_pkg::record_t'(ram_rdata);
    assign ram_raddr = idx_reg[IDX_W-1:0];

    // Round the size up to the alignment; non-power-of-two alignments use
    // the remainder built one bit per cycle.
    assign size_ext  = {1'b0, size_reg};
    assign rem_shift = {rem_reg, size_reg[bit_reg]};
    assign rem_diff  = (rem_shift >= ALIGN_R) ? (rem_shift - ALIGN_R) : rem_shift;

    always_comb
    begin
        if (ALIGN_POW2)
        begin
            rounded_c = (size_ext + ALIGN_M1) & ~ALIGN_M1;
        end
        else if (rem_reg == '0)
        begin
            rounded_c = size_ext;
        end
        else
        begin
            rounded_c = size_ext + ALIGN_C - RND_W'(rem_reg);
        end
    end

    assign bump_sum   = AEXT_W'(bump_reg) + AEXT_W'(rounded_reg);
    assign bump_over  = bump_sum > AEXT_W'(limit_reg);
    assign table_full = count_reg >= TABLE_MAX;
    assign scan_more  = idx_reg < count_reg;

    assign fit_hit  = dv_reg && !rd_rec.busy && (rd_rec.len >= rounded_reg[SIZE_W-1:0]);
    assign find_hit = dv_reg && rd_rec.busy && (rd_rec.start == faddr_reg);

    // Two free records merge only when they touch and the length still fits.
    assign acc_end   = AEXT_W'(acc_reg.start) + AEXT_W'(acc_reg.len);
    assign merge_sum = RND_W'(acc_reg.len) + RND_W'(rd_rec.len);
    assign can_merge = acc_v_reg && !acc_reg.busy && !rd_rec.busy
                       && (acc_end == AEXT_W'(rd_rec.start)) && !merge_sum[SIZE_W];

    // Compaction restarts at the record before the one just freed.
    assign merge_first = (tag_reg == '0) ? '0 : (tag_reg - IDX_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == ffha_pkg::OP_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            state_next = ffha_pkg::S_DONE;
                        end
                        else if (ALIGN_POW2)
                        begin
                            state_next = ffha_pkg::S_SIZE;
                        end
                        else
                        begin
                            state_next = ffha_pkg::S_ROUND;
                        end
                    end
                    else if (free_address == '0)
                    begin
                        state_next = ffha_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ffha_pkg::S_FIND;
                    end
                end
            end
            ffha_pkg::S_ROUND:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ffha_pkg::S_SIZE;
                end
            end
            ffha_pkg::S_SIZE:
            begin
                if (rounded_c[SIZE_W])
                begin
                    state_next = ffha_pkg::S_DONE;
                end
                else
                begin
                    state_next = ffha_pkg::S_FIT;
                end
            end
            ffha_pkg::S_FIT:
            begin
                if (fit_hit)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
                else if (!scan_more)
                begin
                    state_next = ffha_pkg::S_BUMP;
                end
            end
            ffha_pkg::S_BUMP:
            begin
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_FIND:
            begin
                if (find_hit)
                begin
                    state_next = ffha_pkg::S_MERGE;
                end
                else if (!scan_more)
                begin
                    state_next = ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_MERGE:
            begin
                if (!scan_more && !dv_reg)
                begin
                    state_next = ffha_pkg::S_FLUSH;
                end
            end
            ffha_pkg::S_FLUSH:
            begin
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, RAM control and result
    always_comb
    begin
        count_next      = count_reg;
        bump_next       = bump_reg;
        limit_next      = limit_reg;
        used_next       = used_reg;
        unused_next     = unused_reg;
        live_next       = live_reg;
        dv_next         = dv_reg;
        acc_v_next      = acc_v_reg;
        out_valid_next  = out_valid_reg;
        size_next       = size_reg;
        faddr_next      = faddr_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        rounded_next    = rounded_reg;
        idx_next        = idx_reg;
        tag_next        = tag_reg;
        wr_next         = wr_reg;
        acc_next        = acc_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        address_next    = address_reg;
        status_next     = status_reg;
        alloc_out_next  = alloc_out_reg;
        free_out_next   = free_out_reg;
        live_out_next   = live_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wrec        = '0;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next       = request_size;
                    faddr_next      = free_address;
                    rem_next        = '0;
                    bit_next        = BIT_W'(SIZE_W - 1);
                    idx_next        = '0;
                    dv_next         = 1'b0;
                    res_addr_next   = '0;
                    res_status_next = ffha_pkg::STATUS_OK;
                    if (operation == ffha_pkg::OP_ALLOC && request_size == '0)
                    begin
                        res_status_next = ffha_pkg::STATUS_ZERO_SIZE;
                    end
                end
            end
            ffha_pkg::S_ROUND:
            begin
                rem_next = rem_diff[REM_W-1:0];
                bit_next = bit_reg - BIT_W'(1);
            end
            ffha_pkg::S_SIZE:
            begin
                rounded_next = rounded_c;
                if (rounded_c[SIZE_W])
                begin
                    res_status_next = ffha_pkg::STATUS_NO_MEMORY;
                end
            end
            ffha_pkg::S_FIT:
            begin
                if (fit_hit)
                begin
                    // reuse the whole block, no split
                    ram_we          = 1'b1;
                    ram_waddr       = tag_reg;
                    ram_wrec        = rd_rec;
                    ram_wrec.busy   = 1'b1;
                    used_next       = used_reg + ADDR_W'(rd_rec.len);
                    unused_next     = unused_reg - ADDR_W'(rd_rec.len);
                    live_next       = live_reg + CNT_W'(1);
                    res_addr_next   = rd_rec.start;
                    res_status_next = ffha_pkg::STATUS_OK;
                    dv_next         = 1'b0;
                end
                else if (scan_more)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    tag_next = idx_reg[IDX_W-1:0];
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
            end
            ffha_pkg::S_BUMP:
            begin
                if (bump_over || table_full)
                begin
                    res_status_next = ffha_pkg::STATUS_NO_MEMORY;
                end
                else
                begin
                    // new records always land above every existing one
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[IDX_W-1:0];
                    ram_wrec.start  = bump_reg;
                    ram_wrec.len    = rounded_reg[SIZE_W-1:0];
                    ram_wrec.busy   = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    bump_next       = bump_sum[ADDR_W-1:0];
                    used_next       = used_reg + ADDR_W'(rounded_reg);
                    live_next       = live_reg + CNT_W'(1);
                    res_addr_next   = bump_reg;
                    res_status_next = ffha_pkg::STATUS_OK;
                end
            end
            ffha_pkg::S_FIND:
            begin
                if (find_hit)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = tag_reg;
                    ram_wrec        = rd_rec;
                    ram_wrec.busy   = 1'b0;
                    used_next       = used_reg - ADDR_W'(rd_rec.len);
                    unused_next     = unused_reg + ADDR_W'(rd_rec.len);
                    live_next       = live_reg - CNT_W'(1);
                    res_status_next = ffha_pkg::STATUS_OK;
                    idx_next        = CNT_W'(merge_first);
                    wr_next         = merge_first;
                    dv_next         = 1'b0;
                    acc_v_next      = 1'b0;
                end
                else if (scan_more)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    tag_next = idx_reg[IDX_W-1:0];
                    dv_next  = 1'b1;
                end
                else
                begin
                    res_status_next = ffha_pkg::STATUS_UNKNOWN_FREE;
                    dv_next         = 1'b0;
                end
            end
            ffha_pkg::S_MERGE:
            begin
                // advance the read pointer ahead of the compacting writer
                if (scan_more)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (dv_reg)
                begin
                    if (!acc_v_reg)
                    begin
                        acc_next   = rd_rec;
                        acc_v_next = 1'b1;
                    end
                    else if (can_merge)
                    begin
                        acc_next.len = merge_sum[SIZE_W-1:0];
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_reg;
                        ram_wrec  = acc_reg;
                        wr_next   = wr_reg + IDX_W'(1);
                        acc_next  = rd_rec;
                    end
                end
            end
            ffha_pkg::S_FLUSH:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_reg;
                ram_wrec   = acc_reg;
                count_next = CNT_W'(wr_reg) + CNT_W'(1);
                acc_v_next = 1'b0;
            end
            ffha_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    address_next   = res_addr_reg;
                    status_next    = res_status_reg;
                    alloc_out_next = used_reg;
                    free_out_next  = unused_reg;
                    live_out_next  = LIVE_W'(live_reg);
                end
            end
            default:
            begin
                dv_next = 1'b0;
            end
        endcase

        // the user must make configuration writes only while idle; the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                ffha_pkg::CFG_HEAP_BASE:
                begin
                    if (count_reg == '0)
                    begin
                        bump_next = cfg_data;
                    end
                end
                ffha_pkg::CFG_HEAP_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_IDLE;
            count_reg     <= '0;
            bump_reg      <= ffha_pkg::HEAP_BASE_RESET;
            limit_reg     <= ffha_pkg::HEAP_LIMIT_RESET;
            used_reg      <= '0;
            unused_reg    <= '0;
            live_reg      <= '0;
            dv_reg        <= 1'b0;
            acc_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            limit_reg     <= limit_next;
            used_reg      <= used_next;
            unused_reg    <= unused_next;
            live_reg      <= live_next;
            dv_reg        <= dv_next;
            acc_v_reg     <= acc_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        faddr_reg      <= faddr_next;
        rem_reg        <= rem_next;
        bit_reg        <= bit_next;
        rounded_reg    <= rounded_next;
        idx_reg        <= idx_next;
        tag_reg        <= tag_next;
        wr_reg         <= wr_next;
        acc_reg        <= acc_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        address_reg    <= address_next;
        status_reg     <= status_next;
        alloc_out_reg  <= alloc_out_next;
        free_out_reg   <= free_out_next;
        live_out_reg   <= live_out_next;
    end

    assign in_ready        = (state_reg == ffha_pkg::S_IDLE);
    assign out_valid       = out_valid_reg;
    assign address         = address_reg;
    assign status          = status_reg;
    assign allocated_bytes = alloc_out_reg;
    assign free_bytes      = free_out_reg;
    assign live_blocks     = live_out_reg;

    // busy records are a subset of the table
    assert property (@(posedge clk) disable iff (!rst_n) live_reg <= count_reg)
        else $error("live block count exceeds record count");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= TABLE_MAX)
        else $error("record count beyond table depth");

    // the compacting writer must never overtake the read pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffha_pkg::S_MERGE && ram_we) |-> (CNT_W'(wr_reg) < idx_reg))
        else $error("merge write overtook the read pointer");

    // an accepted request always enters the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ffha_pkg::S_IDLE))
        else $error("accepted request did not start");

endmodule
